// File: rtl/smrb_pkg.sv
package smrb_pkg;

  // Longest burst in bytes; longer requests are clipped to this
  localparam int MAX_BURST = 256;
  localparam int BLEFT_W   = $clog2(MAX_BURST + 1);

  localparam int ADDR_W  = 7;
  localparam int COUNT_W = 9;
  localparam int BYTE_W  = 8;
  localparam int BIT_W   = $clog2(BYTE_W);

  // Last bit index within a byte
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BYTE_W - 1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_DATA  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WLOW  = 3'd1,
    PH_WHIGH = 3'd2,
    PH_WEND  = 3'd3,
    PH_RHIGH = 3'd4,
    PH_RLOW  = 3'd5,
    PH_WAIT  = 3'd6
  } phase_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  reg_address;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  write_byte;
    logic               miso_level;
  } in_item_t;

  typedef struct packed {
    logic              chip_select_n;
    logic              serial_clock;
    logic              serial_out;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              need_write_byte;
    logic              busy_res;
    logic              burst_done;
    logic              command_error;
  } out_item_t;

endpackage

// File: rtl/smrb_in_if.sv
interface smrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] reg_address;
  logic [8:0] byte_count;
  logic [7:0] write_byte;
  logic       miso_level;

  modport source (output valid, mode, reg_address, byte_count, write_byte, miso_level,
                  input ready);
  modport sink (input valid, mode, reg_address, byte_count, write_byte, miso_level,
                output ready);
endinterface

// File: rtl/smrb_out_if.sv
interface smrb_out_if;
  logic       valid;
  logic       ready;
  logic       chip_select_n;
  logic       serial_clock;
  logic       serial_out;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       need_write_byte;
  logic       busy_res;
  logic       burst_done;
  logic       command_error;

  modport source (output valid, chip_select_n, serial_clock, serial_out, read_byte,
                  read_valid, need_write_byte, busy_res, burst_done, command_error,
                  input ready);
  modport sink (input valid, chip_select_n, serial_clock, serial_out, read_byte,
                read_valid, need_write_byte, busy_res, burst_done, command_error,
                output ready);
endinterface

// File: rtl/smrb_engine.sv
module smrb_engine
  import smrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  phase_t             phase, phase_next;
  logic [BIT_W-1:0]   bit_counter, bit_counter_next;
  logic [BYTE_W-1:0]  shift_register, shift_register_next;
  logic [BLEFT_W-1:0] bytes_left, bytes_left_next;
  logic               is_write, is_write_next;
  logic               cs_n, cs_n_next;
  logic               sclk, sclk_next;
  logic               mosi, mosi_next;

  logic               start_cmd;
  logic               last_bit;
  logic [BLEFT_W-1:0] count_sat;
  logic [BLEFT_W-1:0] bytes_dec;
  logic [BYTE_W-1:0]  read_shift;

  assign start_cmd  = (item.mode == MODE_READ) || (item.mode == MODE_WRITE);
  assign last_bit   = (bit_counter == LAST_BIT);
  assign count_sat  = (int'(item.byte_count) > MAX_BURST) ? BLEFT_W'(MAX_BURST)
                                                          : BLEFT_W'(item.byte_count);
  assign bytes_dec  = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
  assign read_shift = {shift_register[BYTE_W-2:0], item.miso_level};

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:  if (start_cmd) phase_next = PH_WHIGH;
      PH_WAIT:  if (item.mode == MODE_DATA) phase_next = PH_WHIGH;
      PH_WLOW:  phase_next = PH_WHIGH;
      PH_WHIGH: phase_next = last_bit ? PH_WEND : PH_WLOW;
      PH_WEND: begin
        if (bytes_left == '0) phase_next = PH_IDLE;
        else if (is_write) phase_next = PH_WAIT;
        else phase_next = PH_RHIGH;
      end
      PH_RHIGH: phase_next = PH_RLOW;
      PH_RLOW: begin
        if (last_bit && (bytes_dec == '0)) phase_next = PH_IDLE;
        else phase_next = PH_RHIGH;
      end
      default:  phase_next = PH_IDLE;
    endcase
  end

  // Datapath and pin updates
  always_comb begin
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    bytes_left_next     = bytes_left;
    is_write_next       = is_write;
    cs_n_next           = cs_n;
    sclk_next           = sclk;
    mosi_next           = mosi;
    result              = '0;
    case (phase)
      PH_IDLE: begin
        if (start_cmd) begin
          is_write_next       = (item.mode == MODE_WRITE);
          shift_register_next = {(item.mode == MODE_WRITE), item.reg_address};
          bytes_left_next     = count_sat;
          bit_counter_next    = '0;
          cs_n_next           = 1'b0;
          sclk_next           = 1'b0;
          mosi_next           = (item.mode == MODE_WRITE);
        end else if (item.mode == MODE_DATA) begin
          result.command_error = 1'b1;
        end
      end
      PH_WAIT: begin
        if (item.mode == MODE_DATA) begin
          shift_register_next = item.write_byte;
          bytes_left_next     = bytes_dec;
          bit_counter_next    = '0;
          sclk_next           = 1'b0;
          mosi_next           = item.write_byte[BYTE_W-1];
        end else if (item.mode != MODE_TICK) begin
          result.command_error = 1'b1;
        end
      end
      PH_WLOW: begin
        result.command_error = (item.mode != MODE_TICK);
        sclk_next            = 1'b0;
        mosi_next            = shift_register[BYTE_W-1];
      end
      PH_WHIGH: begin
        result.command_error = (item.mode != MODE_TICK);
        sclk_next            = 1'b1;
        shift_register_next  = {shift_register[BYTE_W-2:0], 1'b0};
        bit_counter_next     = bit_counter + 1'b1;
      end
      PH_WEND: begin
        result.command_error = (item.mode != MODE_TICK);
        sclk_next            = 1'b0;
        mosi_next            = 1'b0;
        if (bytes_left == '0) begin
          cs_n_next         = 1'b1;
          result.burst_done = 1'b1;
        end
      end
      PH_RHIGH: begin
        result.command_error = (item.mode != MODE_TICK);
        sclk_next            = 1'b1;
      end
      PH_RLOW: begin
        result.command_error = (item.mode != MODE_TICK);
        shift_register_next  = read_shift;
        sclk_next            = 1'b0;
        bit_counter_next     = bit_counter + 1'b1;
        if (last_bit) begin
          result.read_byte  = read_shift;
          result.read_valid = 1'b1;
          bytes_left_next   = bytes_dec;
          if (bytes_dec == '0) begin
            cs_n_next         = 1'b1;
            mosi_next         = 1'b0;
            result.burst_done = 1'b1;
          end
        end
      end
      default: begin
        result.command_error = (item.mode != MODE_TICK);
      end
    endcase
    result.chip_select_n   = cs_n_next;
    result.serial_clock    = sclk_next;
    result.serial_out      = mosi_next;
    result.need_write_byte = (phase_next == PH_WAIT);
    result.busy_res        = (phase_next != PH_IDLE);
  end

  // State registers, one tick per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_counter    <= '0;
      shift_register <= '0;
      bytes_left     <= '0;
      is_write       <= 1'b0;
      cs_n           <= 1'b1;
      sclk           <= 1'b0;
      mosi           <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      bit_counter    <= bit_counter_next;
      shift_register <= shift_register_next;
      bytes_left     <= bytes_left_next;
      is_write       <= is_write_next;
      cs_n           <= cs_n_next;
      sclk           <= sclk_next;
      mosi           <= mosi_next;
    end
  end

  // Chip select is low exactly while a burst runs
  a_cs_busy: assert property (@(posedge clk) disable iff (rst)
    cs_n == (phase == PH_IDLE))
    else $error("chip select out of step with phase");

  // SCLK is low in every phase that precedes a rising edge or waits
  a_sclk_low: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WHIGH || phase == PH_RHIGH || phase == PH_IDLE || phase == PH_WAIT)
    |-> !sclk)
    else $error("SCLK high in a low phase");

  // Remaining byte count never exceeds the burst limit
  a_bytes_max: assert property (@(posedge clk) disable iff (rst)
    int'(bytes_left) <= MAX_BURST)
    else $error("burst count out of range");

  // State moves only on a tick
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(shift_register) && $stable(bytes_left))
    else $error("state changed without a tick");

endmodule

// File: rtl/spi_master_register_burst_core.sv
// Channel  Role    Payload
// cmd      sink    mode, reg_address, byte_count, write_byte, miso_level
// res      source  chip_select_n, serial_clock, serial_out, read_byte, read_valid,
//                  need_write_byte, busy_res, burst_done, command_error
//
// One transaction on cmd is one pin tick and yields one transaction on res.
// Sustained rate is one tick per cycle while res does not stall; a tick passes the input
// register, then the state update writes the result register.
// The SPI state advances only when the result register is free to take the tick.
// Synchronous reset returns to idle: chip select high, SCLK and MOSI low.
// A stall on res holds both stages; cmd stays ready while its register can drain.
module spi_master_register_burst_core
  import smrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  smrb_in_if.sink    cmd,
  smrb_out_if.source res
);

  logic      s1_valid;
  in_item_t  s1_item;
  logic      res_valid;
  out_item_t res_item;
  out_item_t eng_result;
  logic      load;
  logic      step;

  assign load      = !res_valid || res.ready;
  assign step      = s1_valid && load;
  assign cmd.ready = !s1_valid || load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item.mode        <= mode_t'(cmd.mode);
      s1_item.reg_address <= cmd.reg_address;
      s1_item.byte_count  <= cmd.byte_count;
      s1_item.write_byte  <= cmd.write_byte;
      s1_item.miso_level  <= cmd.miso_level;
    end
  end

  smrb_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .result (eng_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_item <= eng_result;
    end
  end

  assign res.valid           = res_valid;
  assign res.chip_select_n   = res_item.chip_select_n;
  assign res.serial_clock    = res_item.serial_clock;
  assign res.serial_out      = res_item.serial_out;
  assign res.read_byte       = res_item.read_byte;
  assign res.read_valid      = res_item.read_valid;
  assign res.need_write_byte = res_item.need_write_byte;
  assign res.busy_res        = res_item.busy_res;
  assign res.burst_done      = res_item.burst_done;
  assign res.command_error   = res_item.command_error;

endmodule

// File: tb/spi_pin_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts pin levels per tick and compares results in order
module spi_pin_checker
  import smrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  smrb_in_if          cmd,
  smrb_out_if         res,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  // Predicted SPI master state
  phase_t             ph;
  logic [BIT_W-1:0]   bit_idx;
  logic [BYTE_W-1:0]  shreg;
  logic [BLEFT_W-1:0] bytes_owed;
  logic               write_burst;
  logic               cs_n;
  logic               sclk;
  logic               mosi;

  out_item_t   awaited_pins[$];
  out_item_t   want;
  in_item_t    seen;
  int unsigned result_idx;

  // Put the next bit on MOSI with SCLK low
  function automatic void drive_bit();
    sclk = 1'b0;
    mosi = shreg[BYTE_W-1];
    ph   = PH_WHIGH;
  endfunction

  function automatic void release_bus();
    cs_n = 1'b1;
    sclk = 1'b0;
    mosi = 1'b0;
    ph   = PH_IDLE;
  endfunction

  // One pin tick: update state, return pin levels after the tick
  function automatic out_item_t spi_pin_tick(in_item_t it);
    out_item_t r;
    r = '0;
    case (ph)
      PH_IDLE: begin
        if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
          write_burst = (it.mode == MODE_WRITE);
          shreg       = {write_burst, it.reg_address};
          bytes_owed  = (it.byte_count > MAX_BURST) ? BLEFT_W'(MAX_BURST)
                                                    : BLEFT_W'(it.byte_count);
          bit_idx     = '0;
          cs_n        = 1'b0;
          drive_bit();
        end else if (it.mode == MODE_DATA) begin
          r.command_error = 1'b1;
        end
      end
      PH_WAIT: begin
        if (it.mode == MODE_DATA) begin
          shreg = it.write_byte;
          if (bytes_owed != 0) bytes_owed--;
          bit_idx = '0;
          drive_bit();
        end else if (it.mode != MODE_TICK) begin
          r.command_error = 1'b1;
        end
      end
      default: begin
        // anything but a plain tick is misplaced here; the tick still runs
        r.command_error = (it.mode != MODE_TICK);
        case (ph)
          PH_WLOW: drive_bit();
          PH_WHIGH: begin
            sclk    = 1'b1;
            shreg   = shreg << 1;
            bit_idx = bit_idx + 1'b1;
            ph      = (bit_idx == '0) ? PH_WEND : PH_WLOW;
          end
          PH_WEND: begin
            sclk = 1'b0;
            mosi = 1'b0;
            if (bytes_owed == 0) begin
              release_bus();
              r.burst_done = 1'b1;
            end else begin
              ph = write_burst ? PH_WAIT : PH_RHIGH;
            end
          end
          PH_RHIGH: begin
            sclk = 1'b1;
            ph   = PH_RLOW;
          end
          PH_RLOW: begin
            shreg   = {shreg[BYTE_W-2:0], it.miso_level};
            sclk    = 1'b0;
            bit_idx = bit_idx + 1'b1;
            ph      = PH_RHIGH;
            if (bit_idx == '0) begin
              r.read_byte  = shreg;
              r.read_valid = 1'b1;
              if (bytes_owed != 0) bytes_owed--;
              if (bytes_owed == 0) begin
                release_bus();
                r.burst_done = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
    r.chip_select_n   = cs_n;
    r.serial_clock    = sclk;
    r.serial_out      = mosi;
    r.need_write_byte = (ph == PH_WAIT);
    r.busy_res        = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [BYTE_W-1:0] got,
                             logic [BYTE_W-1:0] exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("result %0d %s is %0h, predicted %0h",
                              result_idx, field, got, exp_val));
  endtask

  task automatic check_bit(string field, logic got, logic exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("result %0d %s is %0b, predicted %0b",
                              result_idx, field, got, exp_val));
  endtask

  // Compare results first so a result can never match its own transaction
  always @(posedge clk) begin
    if (rst) begin
      ph          = PH_IDLE;
      bit_idx     = '0;
      shreg       = '0;
      bytes_owed  = '0;
      write_burst = 1'b0;
      cs_n        = 1'b1;
      sclk        = 1'b0;
      mosi        = 1'b0;
      awaited_pins.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_pins.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing predicted", result_idx));
        end else begin
          want = awaited_pins.pop_front();
          check_bit("chip_select_n", res.chip_select_n, want.chip_select_n);
          check_bit("serial_clock", res.serial_clock, want.serial_clock);
          check_bit("serial_out", res.serial_out, want.serial_out);
          check_field("read_byte", res.read_byte, want.read_byte);
          check_bit("read_valid", res.read_valid, want.read_valid);
          check_bit("need_write_byte", res.need_write_byte, want.need_write_byte);
          check_bit("busy_res", res.busy_res, want.busy_res);
          check_bit("burst_done", res.burst_done, want.burst_done);
          check_bit("command_error", res.command_error, want.command_error);
        end
        result_idx++;
      end
      if (cmd.valid && cmd.ready) begin
        seen.mode        = mode_t'(cmd.mode);
        seen.reg_address = cmd.reg_address;
        seen.byte_count  = cmd.byte_count;
        seen.write_byte  = cmd.write_byte;
        seen.miso_level  = cmd.miso_level;
        awaited_pins.push_back(spi_pin_tick(seen));
      end
    end
    outstanding = awaited_pins.size();
  end

endmodule

// File: tb/spi_master_register_burst_core_tb.sv
`timescale 1ns / 1ps

module spi_master_register_burst_core_tb
  import smrb_pkg::*;
;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_TICKS = 1000;

  // Where a tick falls in a burst; decides which commands are misplaced there
  typedef enum {AT_IDLE, AT_SHIFT, AT_WAIT} slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smrb_in_if  cmd_if ();
  smrb_out_if res_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned ticks_sent;
  int          cycles;
  int          miso_one_pct = 50;
  logic        src_steady;
  logic        snk_steady;
  logic        long_hold = 1'b0;
  logic [7:0]  set_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spi_master_register_burst_core u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  spi_pin_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_if),
    .res        (res_if),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // One tick transaction, after a random idle gap unless the source is steady
  task automatic drive_tick(mode_t m, logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                            logic [BYTE_W-1:0] wb);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.mode        <= m;
    cmd_if.reg_address <= addr;
    cmd_if.byte_count  <= cnt;
    cmd_if.write_byte  <= wb;
    cmd_if.miso_level  <= ($urandom_range(0, 99) < miso_one_pct);
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Plain ticks; some carry a command that is misplaced at this point
  task automatic tick_run(int n, slot_t slot, int noise_pct);
    mode_t m;
    for (int i = 0; i < n; i++) begin
      m = MODE_TICK;
      if ($urandom_range(0, 99) < noise_pct) begin
        case (slot)
          AT_IDLE: m = MODE_DATA;
          AT_WAIT: m = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
          default: begin
            case ($urandom_range(0, 2))
              0:       m = MODE_READ;
              1:       m = MODE_WRITE;
              default: m = MODE_DATA;
            endcase
          end
        endcase
      end
      drive_tick(m, ADDR_W'($urandom), COUNT_W'($urandom), BYTE_W'($urandom));
    end
  endtask

  // Well-formed burst: start, address byte, then each data byte
  task automatic spi_burst(logic wr, logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt,
                           int noise_pct);
    int         nbytes;
    logic [7:0] data;
    nbytes = (cnt > MAX_BURST) ? MAX_BURST : cnt;
    drive_tick(wr ? MODE_WRITE : MODE_READ, addr, cnt, BYTE_W'($urandom));
    tick_run(16, AT_SHIFT, noise_pct);
    repeat (nbytes) begin
      if (wr) begin
        tick_run($urandom_range(0, 3), AT_WAIT, noise_pct);
        data = (set_bytes.size() > 0) ? set_bytes.pop_front() : 8'($urandom);
        drive_tick(MODE_DATA, ADDR_W'($urandom), COUNT_W'($urandom), data);
      end
      tick_run(16, AT_SHIFT, noise_pct);
    end
  endtask

  // Stimulus
  initial begin
    int                 random_end;
    int                 noise;
    logic [COUNT_W-1:0] cnt;
    cmd_if.valid       <= 1'b0;
    cmd_if.mode        <= MODE_TICK;
    cmd_if.reg_address <= '0;
    cmd_if.byte_count  <= '0;
    cmd_if.write_byte  <= '0;
    cmd_if.miso_level  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: data with no burst, commands on every tick of a burst,
    // zero-length bursts at address extremes, data and MISO extremes
    src_steady = 1'b1;
    drive_tick(MODE_DATA, 7'h55, 9'h0AA, 8'h5A);
    tick_run(2, AT_IDLE, 0);
    spi_burst(1'b0, 7'h7F, 9'd0, 100);
    spi_burst(1'b1, 7'h00, 9'd0, 0);
    set_bytes.push_back(8'hFF);
    set_bytes.push_back(8'h00);
    src_steady = 1'b0;
    spi_burst(1'b1, 7'h2A, 9'd2, 30);
    miso_one_pct = 100;
    spi_burst(1'b0, 7'h15, 9'd1, 0);
    miso_one_pct = 0;
    spi_burst(1'b0, 7'h6A, 9'd1, 0);
    miso_one_pct = 50;

    // random bursts, mostly short, some with misplaced commands
    random_end = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < random_end) begin
      src_steady = ($urandom_range(0, 3) == 0);
      noise      = ($urandom_range(0, 3) == 0) ? 0 : 8;
      case ($urandom_range(0, 9))
        0:       cnt = '0;
        9:       cnt = 9'($urandom_range(4, 12));
        default: cnt = 9'($urandom_range(1, 3));
      endcase
      spi_burst(1'($urandom_range(0, 1)), ADDR_W'($urandom), cnt, noise);
      tick_run($urandom_range(0, 4), AT_IDLE, noise * 3);
    end

    cmd_if.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls, with steady stretches
  initial begin
    int gap;
    int served;
    res_if.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (served % 32 == 0) snk_steady = ($urandom_range(0, 3) == 0);
      gap = snk_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0 || long_hold) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (long_hold) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      served++;
    end
  end

  // Long result stall while ticks keep coming, so the pipeline backs up
  initial begin
    wait (ticks_sent >= 400);
    long_hold <= 1'b1;
    repeat (200) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
